@@ rtl/sema_pkg.sv @@
package sema_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int FRAC_BITS       = 16;
  localparam int HALF_LSB        = 32768;
  localparam int MIN_STAT_COUNT  = 10;
  localparam int ALPHA_ONE       = 65536;
  localparam int ALPHA_WIDTH     = 17;
  localparam int CAL_WIDTH       = 16;
  localparam int SIGMA_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam int ALU_WIDTH      = 64;
  localparam int ALU_STEP_WIDTH = 7;

  localparam int CAL_COUNT_RST  = 10;
  localparam int ALPHA_RST      = 6554;
  localparam int SIGMA_RST      = 768;
  localparam int VALID_MIN_RST  = -12800;
  localparam int VALID_MAX_RST  = 51200;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CAL_COUNT,
    CFG_ALPHA,
    CFG_SIGMA,
    CFG_VALID_MIN,
    CFG_VALID_MAX,
    CFG_ALARM_HIGH,
    CFG_ALARM_LOW
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEV_SQ,
    ST_DEV_N,
    ST_SIG_SQ,
    ST_SIG_SUM,
    ST_FILT_SEL,
    ST_FILT,
    ST_DIV,
    ST_VAR_CHK,
    ST_VAR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                      start;
    logic                      div;
    logic [ALU_STEP_WIDTH-1:0] steps;
  } alu_req_t;

endpackage

@@ rtl/sema_ifs.sv @@
interface sema_sample_if import sema_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sema_result_if import sema_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_value;
  logic signed [SAMPLE_WIDTH-1:0] running_mean;
  logic                           outlier_flag;
  logic                           range_error;
  logic                           above_high;
  logic                           below_low;
  logic                           is_calibrated;

  modport source (output valid, output filtered_value, output running_mean,
                  output outlier_flag, output range_error, output above_high,
                  output below_low, output is_calibrated, input ready);
  modport sink (input valid, input filtered_value, input running_mean,
                input outlier_flag, input range_error, input above_high,
                input below_low, input is_calibrated, output ready);
endinterface

interface sema_cfg_if import sema_pkg::*; #(
  parameter int DATA_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [DATA_WIDTH-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sema_alu.sv @@
module sema_alu import sema_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  alu_req_t                 req,
  input  logic [ALU_WIDTH-1:0]     mcand,
  input  logic [ALU_WIDTH-1:0]     opnd,
  output logic                     busy,
  output logic                     done,
  output logic [2*ALU_WIDTH-1:0]   pr
);

  logic [ALU_STEP_WIDTH-1:0] cnt;
  logic                      div;
  logic [ALU_WIDTH-1:0]      mc;
  logic [ALU_WIDTH:0]        add;
  logic [ALU_WIDTH-1:0]      rem_t;
  logic [ALU_WIDTH-1:0]      rem_n;
  logic                      ge;
  logic [2*ALU_WIDTH-1:0]    pr_next;

  // multiply: lsb first shift-add; divide: restoring, quotient shifts in at the bottom
  always_comb begin
    add   = {1'b0, pr[2*ALU_WIDTH-1:ALU_WIDTH]} + (pr[0] ? {1'b0, mc} : '0);
    rem_t = {pr[2*ALU_WIDTH-2:ALU_WIDTH], pr[ALU_WIDTH-1]};
    ge    = rem_t >= mc;
    rem_n = ge ? rem_t - mc : rem_t;
    if (div) begin
      pr_next = {rem_n, pr[ALU_WIDTH-2:0], ge};
    end else begin
      pr_next = {add, pr[ALU_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ALU_STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div <= req.div;
      mc  <= mcand;
      pr  <= {{ALU_WIDTH{1'b0}}, opnd};
    end else if (busy) begin
      pr <= pr_next;
    end
  end

endmodule

@@ rtl/sema_cfg.sv @@
module sema_cfg import sema_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sema_cfg_if.sink                       cfg,
  output logic [CAL_WIDTH-1:0]           cal_count,
  output logic [ALPHA_WIDTH-1:0]         alpha_eff,
  output logic [SIGMA_WIDTH-1:0]         sigma,
  output logic signed [SAMPLE_WIDTH-1:0] valid_min,
  output logic signed [SAMPLE_WIDTH-1:0] valid_max,
  output logic signed [SAMPLE_WIDTH-1:0] alarm_high,
  output logic signed [SAMPLE_WIDTH-1:0] alarm_low
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [ALPHA_WIDTH-1:0] alpha;

  assign cfg.ready = 1'b1;
  // alpha above one acts as one
  assign alpha_eff = (alpha > ALPHA_WIDTH'(ALPHA_ONE)) ? ALPHA_WIDTH'(ALPHA_ONE) : alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count  <= CAL_WIDTH'(CAL_COUNT_RST);
      alpha      <= ALPHA_WIDTH'(ALPHA_RST);
      sigma      <= SIGMA_WIDTH'(SIGMA_RST);
      valid_min  <= SAMPLE_WIDTH'(VALID_MIN_RST);
      valid_max  <= SAMPLE_WIDTH'(VALID_MAX_RST);
      alarm_high <= SMAX;
      alarm_low  <= SMIN;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_CAL_COUNT:  cal_count  <= cfg.data[CAL_WIDTH-1:0];
        CFG_ALPHA:      alpha      <= cfg.data[ALPHA_WIDTH-1:0];
        CFG_SIGMA:      sigma      <= cfg.data[SIGMA_WIDTH-1:0];
        CFG_VALID_MIN:  valid_min  <= $signed(cfg.data[SAMPLE_WIDTH-1:0]);
        CFG_VALID_MAX:  valid_max  <= $signed(cfg.data[SAMPLE_WIDTH-1:0]);
        CFG_ALARM_HIGH: alarm_high <= $signed(cfg.data[SAMPLE_WIDTH-1:0]);
        CFG_ALARM_LOW:  alarm_low  <= $signed(cfg.data[SAMPLE_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/sensor_ema_outlier_filter.sv @@
// Single-channel sensor conditioner. Samples are range checked, averaged during calibration,
// then screened against the running mean (squared k-sigma test once ten samples are in) and
// fed to an exponential filter plus Welford mean/variance statistics. One sample is worked
// at a time; ready is high only while idle. All products and the division by the count go
// through one shared shift-add / restoring-divide unit that retires one bit per cycle. The
// first calibration sample goes straight to the output; later calibration samples take the
// division, plus the variance term when it is taken; a filtering sample with the outlier
// test takes its products, then the filter product, the division and, when taken, the
// variance term. A finished result waits in an output register, so the next sample can be
// taken meanwhile; a result still waiting when the next one is done adds its wait.
module sensor_ema_outlier_filter import sema_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sema_sample_if.sink   samples,
  sema_result_if.source results,
  sema_cfg_if.sink      cfg
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COUNT_WIDTH;
  localparam int MW     = SW + FRAC_BITS;
  localparam int DW     = SW + FRAC_BITS + 1;
  localparam int PW     = SW + ALPHA_WIDTH + 1;
  localparam int LW     = 4 * FRAC_BITS + CW + FRAC_BITS;
  localparam int DEV_W  = DW - FRAC_BITS;
  localparam int DEV_STEPS = 32;
  localparam int SQ_STEPS  = 32;
  localparam int A2W    = 2 * ALU_WIDTH;

  state_t state, state_next;
  logic   go, go_next;

  logic [CAL_WIDTH-1:0]   cal_count;
  logic [ALPHA_WIDTH-1:0] alpha_eff;
  logic [SIGMA_WIDTH-1:0] sigma;
  logic signed [SW-1:0]   valid_min, valid_max, alarm_high, alarm_low;

  alu_req_t             alu_req;
  logic [ALU_WIDTH-1:0] alu_mcand, alu_opnd;
  logic                 alu_busy, alu_done;
  logic [A2W-1:0]       pr;

  logic signed [SW-1:0] filt;
  logic signed [MW-1:0] mean;
  logic [63:0]          sq;
  logic [CW-1:0]        cnt;
  logic                 cal;
  logic signed [SW-1:0] s_reg;
  logic                 rerr, outl, calib_st;
  logic [LW-1:0]        lhs;
  logic [ALU_WIDTH-1:0] tmp;
  logic [DW-1:0]        d1_mag;
  logic                 d1_neg, d1_pos;

  logic                 out_valid;
  logic signed [SW-1:0] out_filt, out_mean;
  logic                 out_outl, out_rerr, out_high, out_low, out_cal;

  logic                 accept;
  logic                 rerr_c, calib_c;
  logic signed [SW-1:0] s_sel;
  logic [CW-1:0]        n_c;

  logic signed [MW-1:0] x24;
  logic signed [DW-1:0] d;
  logic [DW-1:0]        d_mag;
  logic                 d_neg, d_pos;
  logic [DEV_W-1:0]     dev;
  logic [31:0]          dev_cap;

  logic signed [SW:0]   fd;
  logic [SW:0]          fd_mag;
  logic [PW-1:0]        fa_p;
  logic signed [PW:0]   fa_s, fa_r, fa_sh;
  logic signed [SW-1:0] filt_fa;

  logic signed [MW:0]   mean_r, mean_sh;
  logic signed [SW-1:0] mq, f_out;
  logic [DW-1:0]        q, q_s;
  logic [A2W-1:0]       wv;
  logic [63:0]          term;
  logic [64:0]          sq_add;

  sema_cfg #(.SAMPLE_WIDTH(SW)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cal_count  (cal_count),
    .alpha_eff  (alpha_eff),
    .sigma      (sigma),
    .valid_min  (valid_min),
    .valid_max  (valid_max),
    .alarm_high (alarm_high),
    .alarm_low  (alarm_low)
  );

  sema_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .mcand (alu_mcand),
    .opnd  (alu_opnd),
    .busy  (alu_busy),
    .done  (alu_done),
    .pr    (pr)
  );

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    rerr_c  = (samples.sample < valid_min) || (samples.sample > valid_max);
    s_sel   = rerr_c ? filt : samples.sample;
    n_c     = (cnt == {CW{1'b1}}) ? cnt : cnt + 1'b1;
    calib_c = !cal && (32'(n_c) <= 32'(cal_count));
  end

  // deviation of the working sample from the current mean
  always_comb begin
    x24     = {s_reg, {FRAC_BITS{1'b0}}};
    d       = {x24[MW-1], x24} - {mean[MW-1], mean};
    d_neg   = d[DW-1];
    d_pos   = !d[DW-1] && (|d);
    d_mag   = d_neg ? -d : d;
    dev     = d_mag[DW-1:FRAC_BITS];
    dev_cap = (64'(dev) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(dev);
  end

  // filter: f + ((alpha*(s-f) + half) >>> 16)
  always_comb begin
    fd      = {s_reg[SW-1], s_reg} - {filt[SW-1], filt};
    fd_mag  = fd[SW] ? -fd : fd;
    fa_p    = PW'(pr >> (ALU_WIDTH - ALPHA_WIDTH));
    fa_s    = fd[SW] ? -$signed({1'b0, fa_p}) : $signed({1'b0, fa_p});
    fa_r    = fa_s + $signed((PW+1)'(HALF_LSB));
    fa_sh   = fa_r >>> FRAC_BITS;
    filt_fa = filt + SW'(fa_sh);
  end

  always_comb begin
    mean_r  = $signed({mean[MW-1], mean}) + $signed((MW+1)'(HALF_LSB));
    mean_sh = mean_r >>> FRAC_BITS;
    mq      = SW'(mean_sh);
    f_out   = calib_st ? mq : filt;
    q       = pr[DW-1:0];
    q_s     = d1_neg ? -q : q;
    wv      = pr >> (ALU_WIDTH - DW);
    term    = (|wv[A2W-1:96]) ? '1 : wv[95:32];
    sq_add  = {1'b0, sq} + {1'b0, term};
  end

  always_comb begin
    state_next = state;
    go_next    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          if (calib_c) begin
            if (n_c == CW'(1)) begin
              state_next = ST_OUT;
            end else begin
              state_next = ST_DIV;
              go_next    = 1'b1;
            end
          end else if (32'(n_c) >= 32'(MIN_STAT_COUNT)) begin
            state_next = ST_DEV_SQ;
            go_next    = 1'b1;
          end else begin
            state_next = ST_FILT_SEL;
          end
        end
      end
      ST_DEV_SQ: begin
        if (alu_done) begin
          state_next = ST_DEV_N;
          go_next    = 1'b1;
        end
      end
      ST_DEV_N: begin
        if (alu_done) begin
          state_next = ST_SIG_SQ;
          go_next    = 1'b1;
        end
      end
      ST_SIG_SQ: begin
        if (alu_done) begin
          state_next = ST_SIG_SUM;
          go_next    = 1'b1;
        end
      end
      ST_SIG_SUM: begin
        if (alu_done) state_next = ST_FILT_SEL;
      end
      ST_FILT_SEL: begin
        go_next    = 1'b1;
        state_next = (cnt == CW'(1)) ? ST_DIV : ST_FILT;
      end
      ST_FILT: begin
        if (alu_done) begin
          state_next = ST_DIV;
          go_next    = 1'b1;
        end
      end
      ST_DIV: begin
        if (alu_done) state_next = ST_VAR_CHK;
      end
      ST_VAR_CHK: begin
        // variance term only when old and new deviations share a sign
        if ((d1_pos && d_pos) || (d1_neg && d_neg)) begin
          state_next = ST_VAR;
          go_next    = 1'b1;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_VAR: begin
        if (alu_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_req.start = go;
    alu_req.div   = (state == ST_DIV);
    alu_req.steps = '0;
    alu_mcand     = '0;
    alu_opnd      = '0;
    case (state)
      ST_DEV_SQ: begin
        alu_req.steps = ALU_STEP_WIDTH'(DEV_STEPS);
        alu_mcand     = ALU_WIDTH'(dev_cap);
        alu_opnd      = ALU_WIDTH'(dev_cap);
      end
      ST_DEV_N: begin
        alu_req.steps = ALU_STEP_WIDTH'(CW);
        alu_mcand     = tmp;
        alu_opnd      = ALU_WIDTH'(cnt - 1'b1);
      end
      ST_SIG_SQ: begin
        alu_req.steps = ALU_STEP_WIDTH'(SIGMA_WIDTH);
        alu_mcand     = ALU_WIDTH'(sigma);
        alu_opnd      = ALU_WIDTH'(sigma);
      end
      ST_SIG_SUM: begin
        alu_req.steps = ALU_STEP_WIDTH'(SQ_STEPS);
        alu_mcand     = sq;
        alu_opnd      = tmp;
      end
      ST_FILT: begin
        alu_req.steps = ALU_STEP_WIDTH'(ALPHA_WIDTH);
        alu_mcand     = ALU_WIDTH'(fd_mag);
        alu_opnd      = ALU_WIDTH'(alpha_eff);
      end
      ST_DIV: begin
        // dividend goes in msb aligned
        alu_req.steps = ALU_STEP_WIDTH'(DW);
        alu_mcand     = ALU_WIDTH'(cnt);
        alu_opnd      = ALU_WIDTH'(d_mag) << (ALU_WIDTH - DW);
      end
      ST_VAR: begin
        alu_req.steps = ALU_STEP_WIDTH'(DW);
        alu_mcand     = ALU_WIDTH'(d1_mag);
        alu_opnd      = ALU_WIDTH'(d_mag);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      go        <= 1'b0;
      cnt       <= '0;
      cal       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
      if (accept) begin
        cnt <= n_c;
        if (!calib_c) cal <= 1'b1;
      end
      if (state == ST_OUT && state_next == ST_IDLE) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0;
      mean <= '0;
      sq   <= '0;
    end else begin
      if (accept) begin
        s_reg    <= s_sel;
        rerr     <= rerr_c;
        outl     <= 1'b0;
        calib_st <= calib_c;
        if (calib_c && n_c == CW'(1)) begin
          filt <= s_sel;
          mean <= {s_sel, {FRAC_BITS{1'b0}}};
          sq   <= '0;
        end
      end
      case (state)
        ST_DEV_SQ: if (alu_done) tmp <= pr[ALU_WIDTH+DEV_STEPS-1:ALU_WIDTH-DEV_STEPS];
        ST_DEV_N:  if (alu_done) lhs <= LW'((pr >> (ALU_WIDTH - CW)) << FRAC_BITS);
        ST_SIG_SQ: begin
          if (alu_done) begin
            tmp <= ALU_WIDTH'(pr[ALU_WIDTH+SIGMA_WIDTH-1:ALU_WIDTH-SIGMA_WIDTH]);
          end
        end
        ST_SIG_SUM: begin
          if (alu_done && (A2W'(lhs) > (pr >> (ALU_WIDTH - SQ_STEPS)))) begin
            outl  <= 1'b1;
            s_reg <= filt;
          end
        end
        ST_FILT_SEL: if (cnt == CW'(1)) filt <= s_reg;
        ST_FILT:     if (alu_done) filt <= filt_fa;
        ST_DIV: begin
          if (go) begin
            d1_mag <= d_mag;
            d1_neg <= d_neg;
            d1_pos <= d_pos;
          end
          if (alu_done) mean <= mean + MW'(q_s);
        end
        ST_VAR: if (alu_done) sq <= sq_add[64] ? '1 : sq_add[63:0];
        ST_OUT: begin
          if (state_next == ST_IDLE) begin
            filt     <= f_out;
            out_filt <= f_out;
            out_mean <= mq;
            out_outl <= outl;
            out_rerr <= rerr;
            out_high <= f_out > alarm_high;
            out_low  <= f_out < alarm_low;
            out_cal  <= cal;
          end
        end
        default: ;
      endcase
    end
  end

  assign results.valid          = out_valid;
  assign results.filtered_value = out_filt;
  assign results.running_mean   = out_mean;
  assign results.outlier_flag   = out_outl;
  assign results.range_error    = out_rerr;
  assign results.above_high     = out_high;
  assign results.below_low      = out_low;
  assign results.is_calibrated  = out_cal;

  a_alu_start_idle: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_busy)
    else $error("shared unit started while busy");

  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("sample taken while previous one in work");

  a_outlier_cal: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.outlier_flag |-> results.is_calibrated)
    else $error("outlier flagged during calibration");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cnt >= $past(cnt))
    else $error("sample count went down");

endmodule
